@@ sv/srr_pkg.sv @@
// srr_pkg: shared types and constants of the selective-repeat receiver
// used by srr_win and selective_repeat_receiver; depends on nothing
package srr_pkg;

	// fixed field widths at the block boundary
	localparam int SEQ_NUM_W = 3;
	localparam int DATA_W    = 64;

	// parameter defaults
	localparam int WINDOW_DEF        = 4;
	localparam int SEQ_DEF           = 8;
	localparam int PAYLOAD_WIDTH_DEF = 64;

	// result kinds
	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STORE,
		ST_SCAN,
		ST_DELIVER,
		ST_ACK
	} state_t;

endpackage

@@ sv/srr_ram.sv @@
// srr_ram: generic single write port, single read port ram with registered read
// no dependencies
module srr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/srr_win.sv @@
// srr_win: window arithmetic unit shared by every step of the sequencer
// window membership, slot of a sequence number, base advance; uses srr_pkg
module srr_win #(
	parameter int WINDOW = srr_pkg::WINDOW_DEF,
	parameter int SEQ    = srr_pkg::SEQ_DEF,
	parameter int SEQ_W  = $clog2(SEQ),
	parameter int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic [srr_pkg::SEQ_NUM_W-1:0] seq,
	input  logic [SEQ_W-1:0]              base,
	input  logic [SLOT_W-1:0]             base_slot,
	output logic                          in_win,
	output logic [SLOT_W-1:0]             slot,
	output logic [SEQ_W-1:0]              base_nxt,
	output logic [SLOT_W-1:0]             base_slot_nxt
);

	localparam int CW = ((SEQ_W > srr_pkg::SEQ_NUM_W) ? SEQ_W : srr_pkg::SEQ_NUM_W) + 1;

	logic [CW-1:0]                 seq_ext;
	logic [CW-1:0]                 gap;
	logic [srr_pkg::SEQ_NUM_W-1:0] rem;
	logic                          base_wrap;

	// distance from base modulo SEQ, then window test
	always_comb begin
		seq_ext = CW'(seq);
		gap     = seq_ext + CW'(SEQ) - CW'(base);
		if (gap >= CW'(SEQ)) begin
			gap = gap - CW'(SEQ);
		end
		if (seq_ext >= CW'(SEQ)) begin
			in_win = 1'b0;
		end else if (WINDOW >= SEQ) begin
			in_win = 1'b1;
		end else begin
			in_win = (gap < CW'(WINDOW));
		end
	end

	// slot = seq mod WINDOW by repeated subtraction on a 3-bit value
	always_comb begin
		rem = seq;
		for (int i = 0; i < 7; i++) begin
			if (int'(rem) >= WINDOW) begin
				rem = rem - srr_pkg::SEQ_NUM_W'(WINDOW);
			end
		end
		slot = SLOT_W'(rem);
	end

	// base and its slot step forward together
	always_comb begin
		base_wrap = (base == SEQ_W'(SEQ - 1));
		if (base_wrap) begin
			base_nxt      = '0;
			base_slot_nxt = '0;
		end else begin
			base_nxt = base + SEQ_W'(1);
			if (base_slot == SLOT_W'(WINDOW - 1)) begin
				base_slot_nxt = '0;
			end else begin
				base_slot_nxt = base_slot + SLOT_W'(1);
			end
		end
	end

endmodule

@@ sv/selective_repeat_receiver.sv @@
// selective_repeat_receiver: top level of the selective-repeat receiver
// sequencer, slot flags and output register; uses srr_pkg, srr_win, srr_ram
//
// Receiver side of selective-repeat ARQ. A packet word is taken only while
// in_ready is high, which is whenever the sequencer is idle; a finished result
// may still wait in the output register then. A corrupt packet is taken and
// gives nothing. A good packet is taken and goes to the store step; outside the
// window it goes on to the acknowledge, inside it is stored, then each in-order
// buffered payload is delivered (slot check and ram read, then output load) and
// the scan end leads to the acknowledge. Delivery and acknowledge wait while
// out_free is low. The payload ram and the shared window unit are used once per
// sequencer step. Each packet's results end with the acknowledge, marked last.
module selective_repeat_receiver #(
	parameter int WINDOW        = srr_pkg::WINDOW_DEF,
	parameter int SEQ           = srr_pkg::SEQ_DEF,
	parameter int PAYLOAD_WIDTH = srr_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          checksum_good,
	input  logic [srr_pkg::SEQ_NUM_W-1:0] seq_num,
	input  logic [srr_pkg::DATA_W-1:0]    payload_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [srr_pkg::DATA_W-1:0]    deliver_payload,
	output logic [srr_pkg::SEQ_NUM_W-1:0] ack_num,
	output logic                          last
);

	localparam int SEQ_W  = $clog2(SEQ);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	srr_pkg::state_t state_q, state_nxt;

	logic [SEQ_W-1:0]              base_q;
	logic [SLOT_W-1:0]             bslot_q;
	logic [WINDOW-1:0]             recv_q;
	logic [srr_pkg::SEQ_NUM_W-1:0] seq_q;
	logic [PAYLOAD_WIDTH-1:0]      pay_q;

	logic                          out_valid_q;
	logic                          out_kind_q;
	logic [srr_pkg::DATA_W-1:0]    out_pay_q;
	logic [srr_pkg::SEQ_NUM_W-1:0] out_ack_q;
	logic                          out_last_q;

	logic                     in_win;
	logic [SLOT_W-1:0]        slot;
	logic [SEQ_W-1:0]         base_nxt;
	logic [SLOT_W-1:0]        bslot_nxt;
	logic [PAYLOAD_WIDTH-1:0] ram_rdata;

	logic in_acc;
	logic out_free;
	logic store_en;
	logic take_en;
	logic load_del;
	logic load_ack;

	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// shared window arithmetic
	srr_win #(
		.WINDOW (WINDOW),
		.SEQ    (SEQ),
		.SEQ_W  (SEQ_W),
		.SLOT_W (SLOT_W)
	) u_win (
		.seq           (seq_q),
		.base          (base_q),
		.base_slot     (bslot_q),
		.in_win        (in_win),
		.slot          (slot),
		.base_nxt      (base_nxt),
		.base_slot_nxt (bslot_nxt)
	);

	// buffered payloads, one word per slot
	srr_ram #(
		.WIDTH (PAYLOAD_WIDTH),
		.DEPTH (WINDOW),
		.AW    (SLOT_W)
	) u_ram (
		.clk   (clk),
		.we    (store_en),
		.waddr (slot),
		.wdata (pay_q),
		.re    (take_en),
		.raddr (bslot_q),
		.rdata (ram_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and step controls
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		store_en  = 1'b0;
		take_en   = 1'b0;
		load_del  = 1'b0;
		load_ack  = 1'b0;
		case (state_q)
			srr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && checksum_good) begin
					state_nxt = srr_pkg::ST_STORE;
				end
			end
			srr_pkg::ST_STORE: begin
				store_en  = in_win;
				state_nxt = in_win ? srr_pkg::ST_SCAN : srr_pkg::ST_ACK;
			end
			srr_pkg::ST_SCAN: begin
				if (recv_q[bslot_q]) begin
					take_en   = 1'b1;
					state_nxt = srr_pkg::ST_DELIVER;
				end else begin
					state_nxt = srr_pkg::ST_ACK;
				end
			end
			srr_pkg::ST_DELIVER: begin
				if (out_free) begin
					load_del  = 1'b1;
					state_nxt = srr_pkg::ST_SCAN;
				end
			end
			srr_pkg::ST_ACK: begin
				if (out_free) begin
					load_ack  = 1'b1;
					state_nxt = srr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = srr_pkg::ST_IDLE;
			end
		endcase
	end

	// window base and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bslot_q <= '0;
			recv_q  <= '0;
		end else begin
			if (store_en) begin
				recv_q[slot] <= 1'b1;
			end
			if (take_en) begin
				recv_q[bslot_q] <= 1'b0;
				base_q          <= base_nxt;
				bslot_q         <= bslot_nxt;
			end
		end
	end

	// packet capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			seq_q <= seq_num;
			pay_q <= payload_in[PAYLOAD_WIDTH-1:0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_del || load_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (load_del) begin
			out_kind_q <= srr_pkg::KIND_DELIVER;
			out_pay_q  <= srr_pkg::DATA_W'(ram_rdata);
			out_ack_q  <= '0;
			out_last_q <= 1'b0;
		end else if (load_ack) begin
			out_kind_q <= srr_pkg::KIND_ACK;
			out_pay_q  <= '0;
			out_ack_q  <= seq_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = out_kind_q;
	assign deliver_payload = out_pay_q;
	assign ack_num         = out_ack_q;
	assign last            = out_last_q;

`ifndef ASSERT_OFF
	// a good packet always goes to the store step
	a_good_to_store: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && checksum_good |=> state_q == srr_pkg::ST_STORE)
		else $error("good packet did not enter store step");

	// only the acknowledge closes a packet
	a_last_is_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_kind_q == srr_pkg::KIND_ACK)))
		else $error("last flag does not match result kind");

	// a delivery is only ever reached from a slot check
	a_deliver_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == srr_pkg::ST_DELIVER |->
			$past(state_q) == srr_pkg::ST_SCAN || $past(state_q) == srr_pkg::ST_DELIVER)
		else $error("delivery step entered without slot check");

	// slot pointer stays inside the window and base stays below SEQ
	a_bslot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(bslot_q) < WINDOW && int'(base_q) < SEQ)
		else $error("window base or slot out of range");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// testbench: self-checking bench for the selective-repeat receiver
// predicts in-order deliveries and acks per packet word; needs srr_pkg and the rtl

// one result word as the block presents it
typedef struct {
	logic        kind;
	logic [63:0] data;
	logic [2:0]  ack_no;
	logic        last;
} srr_result_t;

// receive window tracker: mirrors base, slot flags and buffered payloads
class window_tracker;
	bit [2:0]    base;
	bit          held[srr_pkg::WINDOW_DEF];
	bit [63:0]   stash[srr_pkg::WINDOW_DEF];
	srr_result_t due[$];
	int          errors;

	// note one accepted packet word and queue the results it causes
	function void take_packet(bit good, bit [2:0] seq, bit [63:0] data);
		int          gap;
		int          slot;
		srr_result_t r;
		if (!good)
			return;
		gap = (int'(seq) + srr_pkg::SEQ_DEF - int'(base)) % srr_pkg::SEQ_DEF;
		if (gap < srr_pkg::WINDOW_DEF) begin
			slot = int'(seq) % srr_pkg::WINDOW_DEF;
			stash[slot] = data;
			held[slot] = 1'b1;
			// deliver the run of buffered slots starting at base
			while (held[int'(base) % srr_pkg::WINDOW_DEF]) begin
				slot = int'(base) % srr_pkg::WINDOW_DEF;
				r.kind = srr_pkg::KIND_DELIVER;
				r.data = stash[slot];
				r.ack_no = 3'd0;
				r.last = 1'b0;
				due.push_back(r);
				held[slot] = 1'b0;
				base = 3'((int'(base) + 1) % srr_pkg::SEQ_DEF);
			end
		end
		// every good packet ends with its ack
		r.kind = srr_pkg::KIND_ACK;
		r.data = 64'd0;
		r.ack_no = seq;
		r.last = 1'b1;
		due.push_back(r);
	endfunction

	task flag(string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	// compare one accepted result word with the oldest expectation
	task match_result(logic kind, logic [63:0] data, logic [2:0] ack_no, logic last);
		srr_result_t want;
		if (due.size() == 0) begin
			flag($sformatf("unexpected word kind=%b data=%h ack=%0d last=%b",
				kind, data, ack_no, last));
			return;
		end
		want = due.pop_front();
		if (kind !== want.kind)
			flag($sformatf("kind %b, expected %b", kind, want.kind));
		if (data !== want.data)
			flag($sformatf("deliver_payload %h, expected %h", data, want.data));
		if (ack_no !== want.ack_no)
			flag($sformatf("ack_num %0d, expected %0d", ack_no, want.ack_no));
		if (last !== want.last)
			flag($sformatf("last %b, expected %b", last, want.last));
	endtask
endclass

module testbench;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RAND_PER_PHASE = 32;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        checksum_good = 1'b0;
	logic [2:0]  seq_num = 3'd0;
	logic [63:0] payload_in = 64'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [63:0] deliver_payload;
	logic [2:0]  ack_num;
	logic        last;

	int snd_idle = 37;
	int rcv_idle = 53;
	int stall_cnt = 0;

	window_tracker sb = new;

	selective_repeat_receiver DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.checksum_good  (checksum_good),
		.seq_num        (seq_num),
		.payload_in     (payload_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.deliver_payload(deliver_payload),
		.ack_num        (ack_num),
		.last           (last)
	);

	always #5 clk = ~clk;

	// result side: check accepted words, then pick the next ready
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.match_result(kind, deliver_payload, ack_num, last);
		out_ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cnt <= 0;
		else if (stall_cnt >= STALL_LIMIT) begin
			$display("selective_repeat_receiver: mismatch");
			$finish;
		end else
			stall_cnt <= stall_cnt + 1;
	end

	// offer one packet word, with random idle cycles ahead of it
	task send_word(bit good, bit [2:0] seq, bit [63:0] data);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		checksum_good <= good;
		seq_num <= seq;
		payload_in <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_packet(good, seq, data);
	endtask

	// mostly in-window packets around the current base, some outside, some corrupt
	task send_random();
		int        pick;
		bit [63:0] data;
		pick = $urandom_range(0, 99);
		data = {$urandom, $urandom};
		if ($urandom_range(0, 15) == 0)
			data = $urandom_range(0, 1) ? '1 : '0;
		if (pick < 10)
			send_word(1'b0, 3'($urandom_range(0, 7)), data);
		else if (pick < 22)
			send_word(1'b1, sb.base + 3'(srr_pkg::WINDOW_DEF +
				$urandom_range(0, srr_pkg::SEQ_DEF - srr_pkg::WINDOW_DEF - 1)), data);
		else
			send_word(1'b1, sb.base + 3'($urandom_range(0, srr_pkg::WINDOW_DEF - 1)),
				data);
	endtask

	// hold off new words until every expected result has come out
	task drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corrupt word is dropped
		send_word(1'b0, 3'd0, '1);
		// good but outside the window: ack only
		send_word(1'b1, 3'd5, 64'h0123_4567_89ab_cdef);
		// out of order inside the window, then a duplicate overwrite
		send_word(1'b1, 3'd1, '1);
		send_word(1'b1, 3'd1, 64'h5555_5555_5555_5555);
		send_word(1'b1, 3'd2, 64'haaaa_aaaa_aaaa_aaaa);
		send_word(1'b1, 3'd3, '1);
		// gap filled: full window delivered plus ack
		send_word(1'b1, 3'd0, '0);
		// window now 4..7: fill from the top down, wrap base back to 0
		send_word(1'b1, 3'd7, 64'h8000_0000_0000_0001);
		send_word(1'b1, 3'd6, '1);
		send_word(1'b1, 3'd5, '0);
		send_word(1'b1, 3'd4, 64'h7fff_ffff_ffff_fffe);
		// behind the window after the wrap
		send_word(1'b1, 3'd4, '1);
		send_word(1'b1, 3'd7, '0);
		// corrupt words, one carrying an in-window number, change nothing
		send_word(1'b0, 3'd0, '0);
		send_word(1'b0, 3'd7, '1);
		// in-order single deliveries, then an out-of-order pair delivered together
		send_word(1'b1, 3'd0, 64'hdead_beef_0000_ffff);
		send_word(1'b1, 3'd1, 64'hffff_0000_beef_dead);
		send_word(1'b1, 3'd3, 64'h1);
		send_word(1'b1, 3'd2, 64'h2);

		repeat (RAND_PER_PHASE) send_random();
		drain();

		snd_idle = 53;
		rcv_idle = 37;
		repeat (RAND_PER_PHASE) send_random();
		drain();

		snd_idle = 0;
		rcv_idle = 0;
		repeat (RAND_PER_PHASE) send_random();
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("selective_repeat_receiver: match");
		else
			$display("selective_repeat_receiver: mismatch");
		$finish;
	end

endmodule
